### design/tsc_pkg.sv
// shared types, constants and the crc-8 step for the scratchpad crc checker
// no dependencies; used by the top level
`timescale 1ns / 1ps

package tsc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned TEMP_W      = 16;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [BYTE_W-1:0] CRC_POLY    = 8'h8C;
    localparam logic [POS_W-1:0]  CRC_BYTES   = 4'd8;
    localparam logic [POS_W-1:0]  FRAME_BYTES = 4'd9;
    localparam logic [POS_W-1:0]  POS_LOW     = 4'd0;
    localparam logic [POS_W-1:0]  POS_HIGH    = 4'd1;

    localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST = -16'sd880;
    localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = 16'sd2000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_VALID     = 2'd0,
        STATUS_CRC_ERR   = 2'd1,
        STATUS_RANGE_ERR = 2'd2
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] scratch_byte;
        logic              frame_start;
    } in_item_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        status_t                  status;
        logic [BYTE_W-1:0]        computed_crc;
    } out_item_t;

    // reflected crc-8, lsb first, eight unrolled bit steps
    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc_in,
        input logic [BYTE_W-1:0] data_in
    );
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] d;
        logic              mix;
        crc = crc_in;
        d   = data_in;
        for (int k = 0; k < BYTE_W; k++)
        begin
            mix = crc[0] ^ d[0];
            crc = crc >> 1;
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return crc;
    endfunction

endpackage

### design/tsc_stream_if.sv
// valid/ready stream channel carrying one payload item per transfer
// payload type is set per instance; used with the types from tsc_pkg
`timescale 1ns / 1ps

interface tsc_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

### design/temp_scratchpad_crc_checker.sv
// the result of a frame is registered and appears in the cycle after the transfer of its ninth byte
// throughput: one byte per cycle, set by the combinational crc update of the running crc
// register; a waiting result does not stall input as long as the sink takes it
// reset (rst_n, async, active low): framing restarts at byte 0, crc and bytes clear,
// limits return to -880 and 2000, no result pending
`timescale 1ns / 1ps

module temp_scratchpad_crc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    tsc_stream_if.sink                      in_ch,
    tsc_stream_if.source                    out_ch,
    input  logic                            cfg_we,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic signed [tsc_pkg::TEMP_W-1:0] min_temp_reg;
    logic signed [tsc_pkg::TEMP_W-1:0] max_temp_reg;

    logic [tsc_pkg::BYTE_W-1:0] crc_reg,  crc_next;
    logic [tsc_pkg::POS_W-1:0]  pos_reg,  pos_next;
    logic [tsc_pkg::BYTE_W-1:0] low_reg,  low_next;
    logic [tsc_pkg::BYTE_W-1:0] high_reg, high_next;

    logic                       out_valid_reg, out_valid_next;
    tsc_pkg::out_item_t         out_data_reg,  out_data_next;

    logic                       in_fire;
    logic                       result_en;
    logic [tsc_pkg::POS_W-1:0]  pos_eff;
    logic [tsc_pkg::BYTE_W-1:0] crc_base;
    logic signed [tsc_pkg::TEMP_W-1:0] reading;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_temp_reg <= tsc_pkg::MIN_TEMP_RST;
            max_temp_reg <= tsc_pkg::MAX_TEMP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsc_pkg::CFG_MIN_TEMP: min_temp_reg <= cfg_wdata;
                tsc_pkg::CFG_MAX_TEMP: max_temp_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        // a frame start or a finished frame puts the byte at position 0
        if (in_ch.data.frame_start || pos_reg >= tsc_pkg::FRAME_BYTES)
        begin
            pos_eff = tsc_pkg::POS_LOW;
        end
        else
        begin
            pos_eff = pos_reg;
        end

        crc_base  = (pos_eff == tsc_pkg::POS_LOW) ? '0 : crc_reg;
        reading   = {high_reg, low_reg};
        result_en = in_fire && (pos_eff == tsc_pkg::CRC_BYTES);

        crc_next  = crc_reg;
        pos_next  = pos_reg;
        low_next  = low_reg;
        high_next = high_reg;

        if (in_fire)
        begin
            if (pos_eff < tsc_pkg::CRC_BYTES)
            begin
                crc_next = tsc_pkg::crc8_byte(crc_base, in_ch.data.scratch_byte);
                pos_next = pos_eff + 1'b1;
                if (pos_eff == tsc_pkg::POS_LOW)
                begin
                    low_next = in_ch.data.scratch_byte;
                end
                if (pos_eff == tsc_pkg::POS_HIGH)
                begin
                    high_next = in_ch.data.scratch_byte;
                end
            end
            else
            begin
                pos_next = tsc_pkg::POS_LOW;
            end
        end

        out_data_next.temperature  = reading;
        out_data_next.computed_crc = crc_reg;
        if (in_ch.data.scratch_byte != crc_reg)
        begin
            out_data_next.status = tsc_pkg::STATUS_CRC_ERR;
        end
        else if (reading < min_temp_reg || reading > max_temp_reg)
        begin
            out_data_next.status = tsc_pkg::STATUS_RANGE_ERR;
        end
        else
        begin
            out_data_next.status = tsc_pkg::STATUS_VALID;
        end

        if (result_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '0;
            pos_reg       <= tsc_pkg::POS_LOW;
            low_reg       <= '0;
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            pos_reg       <= pos_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        if (result_en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // position never runs past the last byte of a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= tsc_pkg::CRC_BYTES)
        else $error("byte position out of frame");

    // the crc byte of a frame always yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !in_ch.data.frame_start && pos_reg == tsc_pkg::CRC_BYTES
        |=> out_valid_reg)
        else $error("missing result after crc byte");

    // a data byte never produces a result once the old one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !result_en && out_ch.ready |=> !out_valid_reg)
        else $error("spurious result");

    // a valid status means the reading lies within the limits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status == tsc_pkg::STATUS_VALID
        |-> out_data_reg.temperature >= min_temp_reg
            && out_data_reg.temperature <= max_temp_reg)
        else $error("valid status with reading out of range");

    // every crc byte restarts framing
    assert property (@(posedge clk) disable iff (!rst_n)
        result_en |=> pos_reg == tsc_pkg::POS_LOW)
        else $error("framing not restarted after result");

endmodule
